// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define GPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/gpc_pkg.sv =====
// Package: shared types and constants of the grid path cost block.
`timescale 1ns / 1ps

package gpc_pkg;

    localparam int COST_W     = 16;
    localparam int PATH_W     = 27;
    localparam int STORE_W    = 28;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIND_MAX  = 1'd1;

    typedef struct packed {
        logic [COST_W-1:0] cell_cost;
    } cell_in_t;

    typedef struct packed {
        logic [PATH_W-1:0] path_cost;
        logic              grid_done;
    } cost_out_t;

    // Position flags of a cell, travel with it through the pipeline.
    typedef struct packed {
        logic first_row;
        logic first_col;
        logic last_cell;
        logic find_max;
    } cell_tag_t;

endpackage

// ===== design/gpc_stream_if.sv =====
// Interface: valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps

interface gpc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/gpc_line_mem.sv =====
// Line buffer: one-port-write, one-port-read memory with registered read and bypass.
`timescale 1ns / 1ps

module gpc_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 28
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Bypass the write of the same edge so a read never sees stale data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/gpc_seq.sv =====
// Sequencer: configuration registers and row/column position counters.
`timescale 1ns / 1ps

module gpc_seq #(
    parameter int GRID_MAX = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            advance,
    output logic [$clog2(GRID_MAX)-1:0]     col,
    output gpc_pkg::cell_tag_t              tag
);

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int SIZE_W = ($clog2(GRID_MAX + 1) > gpc_pkg::CFG_DATA_W) ?
                            $clog2(GRID_MAX + 1) : gpc_pkg::CFG_DATA_W;
    localparam int RST_SIZE = (GRID_MAX < 1024) ? GRID_MAX : 1024;
    localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_SIZE - 1);

    logic [IDX_W-1:0]  last_reg, last_next;
    logic              max_reg, max_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] size_req;
    logic [SIZE_W-1:0] size_eff;
    logic              col_end;
    logic              row_end;

    // Clamp the requested size to 1..GRID_MAX.
    always_comb
    begin
        size_req = SIZE_W'(cfg_data);
        if (size_req == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (size_req > SIZE_W'(GRID_MAX))
        begin
            size_eff = SIZE_W'(GRID_MAX);
        end
        else
        begin
            size_eff = size_req;
        end
    end

    assign col_end = (col_reg == last_reg);
    assign row_end = (row_reg == last_reg);

    always_comb
    begin
        last_next = last_reg;
        max_next  = max_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                gpc_pkg::REG_GRID_SIZE:
                begin
                    last_next = IDX_W'(size_eff - SIZE_W'(1));
                    col_next  = '0;
                    row_next  = '0;
                end
                gpc_pkg::REG_FIND_MAX:
                begin
                    max_next = cfg_data[0];
                end
                default:
                begin
                    max_next = max_reg;
                end
            endcase
        end
        else if (advance)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= RST_LAST;
            max_reg  <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            last_reg <= last_next;
            max_reg  <= max_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    assign col           = col_reg;
    assign tag.first_row = (row_reg == '0);
    assign tag.first_col = (col_reg == '0);
    assign tag.last_cell = col_end && row_end;
    assign tag.find_max  = max_reg;

endmodule

// ===== design/grid_path_cost_dp.sv =====
// Top level: streaming min/max path cost over a square grid with a line buffer.
//
//  channel   dir  payload                       transfer when
//  cells     in   cell_cost[15:0]               cells.valid && cells.ready
//  results   out  path_cost[26:0], grid_done    results.valid && results.ready
//  cfg       in   cfg_index[0], cfg_data[10:0]  cfg_we
//
// One cell per cycle unless the output stalls; the result is registered after stage 1.
// Stage 0 issues the line-buffer read for the cell's column; stage 1 adds the cost to
// the min/max of the row-below entry and the previous result, writes the line buffer
// and loads the output register. Reset clears the counters and pipeline valids; the
// line buffer is not cleared (every entry is written in the bottom row before use).
// A stalled output holds stage 1; a new cell is taken whenever stage 1 can drain.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module grid_path_cost_dp #(
    parameter int GRID_MAX  = 1024,
    parameter int COST_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gpc_pkg::CFG_DATA_W-1:0] cfg_data,
    gpc_stream_if.sink                     cells,
    gpc_stream_if.source                   results
);

    localparam int IDX_W     = $clog2(GRID_MAX);
    localparam int COST_W    = gpc_pkg::COST_W;
    localparam int STORE_W   = gpc_pkg::STORE_W;
    localparam int PATH_W    = gpc_pkg::PATH_W;
    localparam int MASK_BITS = (COST_BITS < COST_W) ? COST_BITS : COST_W;
    localparam logic [COST_W-1:0] COST_MASK = COST_W'((64'(1) << MASK_BITS) - 64'(1));

    // Input side and sequencer.
    logic                accept;
    logic [IDX_W-1:0]    seq_col;
    gpc_pkg::cell_tag_t  seq_tag;

    // Stage 1 holds the cell whose line-buffer data is arriving.
    logic                s1_valid_reg, s1_valid_next;
    logic [COST_W-1:0]   s1_cost_reg;
    logic [IDX_W-1:0]    s1_col_reg;
    gpc_pkg::cell_tag_t  s1_tag_reg;
    logic                s1_advance;

    // Datapath.
    logic [STORE_W-1:0]  below;
    logic [STORE_W-1:0]  right_reg;
    logic [STORE_W-1:0]  pick;
    logic [STORE_W-1:0]  addend;
    logic [STORE_W-1:0]  result;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    gpc_pkg::cost_out_t  out_data_reg;
    logic                out_free;

    assign out_free     = !out_valid_reg || results.ready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign cells.ready  = !s1_valid_reg || out_free;
    assign accept       = cells.valid && cells.ready;

    gpc_seq #(
        .GRID_MAX (GRID_MAX)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (seq_col),
        .tag       (seq_tag)
    );

    // Read the row-below entry on transfer; write this cell's result when stage 1 drains.
    gpc_line_mem #(
        .DEPTH (GRID_MAX),
        .WIDTH (STORE_W)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (seq_col),
        .rd_data (below),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (result)
    );

    // Pick the neighbor: bottom row uses right only, rightmost column uses below only.
    always_comb
    begin
        if (s1_tag_reg.find_max)
        begin
            pick = (below > right_reg) ? below : right_reg;
        end
        else
        begin
            pick = (below < right_reg) ? below : right_reg;
        end

        if (s1_tag_reg.first_row && s1_tag_reg.first_col)
        begin
            addend = '0;
        end
        else if (s1_tag_reg.first_row)
        begin
            addend = right_reg;
        end
        else if (s1_tag_reg.first_col)
        begin
            addend = below;
        end
        else
        begin
            addend = pick;
        end
        result = STORE_W'(s1_cost_reg) + addend;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the cell and its position on transfer; drop cost bits above COST_BITS.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg <= cells.data.cell_cost & COST_MASK;
            s1_col_reg  <= seq_col;
            s1_tag_reg  <= seq_tag;
        end
    end

    // Advance the result into the output register and keep it as the next right neighbor.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            right_reg              <= result;
            out_data_reg.path_cost <= result[PATH_W-1:0];
            out_data_reg.grid_done <= s1_tag_reg.last_cell;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    `GPC_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_reg,
        "accepted cell did not reach stage 1")

    `GPC_ASSERT_NOW(a_no_accept_over_held, clk, rst_n, accept,
        !(s1_valid_reg && !s1_advance), "cell accepted while stage 1 is held")

    `GPC_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_advance,
        s1_valid_reg && $stable(s1_cost_reg) && $stable(s1_col_reg),
        "held stage 1 changed")

    `GPC_ASSERT_NOW(a_corner_cost, clk, rst_n,
        s1_advance && s1_tag_reg.first_row && s1_tag_reg.first_col,
        result == STORE_W'(s1_cost_reg), "bottom-right cell result is not its own cost")

endmodule
